[sv/tcsw_pkg.sv]
// Shared types, codes and screen geometry for the text console screen writer.
`timescale 1ns / 1ps

package tcsw_pkg;

    // Screen geometry
    localparam int COLS   = 80;
    localparam int ROWS   = 25;
    localparam int CELLS  = COLS * ROWS;
    localparam int ADDR_W = $clog2(CELLS);

    // Blink timing, in frame ticks
    localparam logic [4:0] BLINK_LAST  = 5'd29;
    localparam logic [4:0] BLINK_SHOWN = 5'd15;

    // Byte codes
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // Reset values
    localparam logic [31:0] RESET_CELL_COLOR = 32'hFFFF_FFFF;
    localparam logic [31:0] RESET_TEXT_COLOR = 32'hFFFF_00FF;

    // Configuration register indexes
    localparam logic [7:0] REG_TEXT_COLOR    = 8'd0;
    localparam logic [7:0] REG_CURSOR_ENABLE = 8'd1;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_READ  = 2'd1,
        OP_TICK  = 2'd2,
        OP_NOP   = 2'd3
    } op_t;

    typedef enum logic [5:0] {
        ST_CLEAR  = 6'b000001,
        ST_IDLE   = 6'b000010,
        ST_READ   = 6'b000100,
        ST_SCROLL = 6'b001000,
        ST_FILL   = 6'b010000,
        ST_RESP   = 6'b100000
    } state_t;

    // One queued write into the cell memories
    typedef struct packed {
        logic              valid;
        logic [ADDR_W-1:0] addr;
        logic              from_mem;   // take data from the read port (scroll copy)
        logic              color_en;
        logic [7:0]        chr;
        logic [31:0]       color;
    } cell_wr_t;

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [7:0] row,
                                                    input logic [7:0] col);
        cell_addr = ADDR_W'(row) * ADDR_W'(COLS) + ADDR_W'(col);
    endfunction

endpackage

[sv/text_console_screen_writer.sv]
// Top level of the text console screen writer: sequencer, cursor, blink and cell memories.
`timescale 1ns / 1ps

// Character-cell console of 80 by 25 cells, each a character byte and an RGBA
// colour. Input items arrive on the s_ group (opcode in s_tuser) and every item
// returns exactly one result on the m_ group. After reset the block sweeps both
// cell memories to blank (space, white), one cell a cycle, and accepts no item
// until the sweep is done; configuration writes are taken throughout. One item
// is worked on at a time: a cell read waits on the registered memory read, and
// a new line taken on the bottom row scrolls the screen through the single
// memory read and write port, one cell a cycle. A finished result waits in the
// output register while the next item is taken.
module text_console_screen_writer (
    input  logic        clk,
    input  logic        rst_n,
    // Configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [31:0] cfg_data,
    // Item input
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,    // char_byte[7:0], cell_col[15:8], cell_row[23:16]
    input  logic [1:0]  s_tuser,    // opcode[1:0]
    // Result output
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata     // cursor_col[7:0], cursor_row[15:8], cell_char[23:16],
                                    // cell_color[55:24], cursor_visible[56],
                                    // out_of_range[57], zero fill above
);

    localparam int AW = tcsw_pkg::ADDR_W;

    // Cell memories, one write and one registered read a cycle
    logic [7:0]  char_mem  [tcsw_pkg::CELLS];
    logic [31:0] color_mem [tcsw_pkg::CELLS];
    logic [7:0]  rd_char_reg;
    logic [31:0] rd_color_reg;
    logic [AW-1:0] rd_addr;

    tcsw_pkg::state_t   state_reg, state_next;
    tcsw_pkg::cell_wr_t wr_reg, wr_next;
    logic [AW-1:0] scan_reg, scan_next;

    logic [31:0] text_color_reg;
    logic        cursor_enable_reg;
    logic [7:0]  cursor_x_reg, cursor_x_next;
    logic [7:0]  cursor_y_reg, cursor_y_next;
    logic [4:0]  blink_reg, blink_next;

    // Result fields that belong to a read
    logic [7:0]  res_char_reg, res_char_next;
    logic [31:0] res_color_reg, res_color_next;
    logic        res_oor_reg, res_oor_next;

    logic        m_tvalid_reg;
    logic [63:0] m_tdata_reg;

    // Input fields
    tcsw_pkg::op_t op;
    logic [7:0] in_char, in_col, in_row;

    // Cursor after a backspace, and after advancing one column
    logic [7:0] bs_x, bs_y;
    logic [8:0] adv_x;
    logic       accept;
    logic       out_free;
    logic       in_oor;
    logic       cursor_visible;

    // Shared address unit operands
    logic [7:0]    au_row, au_col;
    logic [AW-1:0] au_addr;

    assign op      = tcsw_pkg::op_t'(s_tuser);
    assign in_char = s_tdata[7:0];
    assign in_col  = s_tdata[15:8];
    assign in_row  = s_tdata[23:16];

    assign cfg_ready = 1'b1;
    // Hold off items while a queued memory write is still in flight
    assign s_tready  = (state_reg == tcsw_pkg::ST_IDLE) && !wr_reg.valid;
    assign accept    = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    assign in_oor = (9'(in_col) >= 9'(tcsw_pkg::COLS)) || (9'(in_row) >= 9'(tcsw_pkg::ROWS));
    assign adv_x  = {1'b0, cursor_x_reg} + 9'd1;
    assign cursor_visible = cursor_enable_reg && (blink_reg < tcsw_pkg::BLINK_SHOWN);

    always_comb
    begin
        bs_x = cursor_x_reg;
        bs_y = cursor_y_reg;
        if (cursor_x_reg != 8'd0)
        begin
            bs_x = cursor_x_reg - 8'd1;
        end
        else if (cursor_y_reg != 8'd0)
        begin
            bs_x = 8'(tcsw_pkg::COLS - 1);
            bs_y = cursor_y_reg - 8'd1;
        end
    end

    // One address multiplier serves reads, backspace and character writes
    always_comb
    begin
        if (op == tcsw_pkg::OP_READ)
        begin
            au_row = in_row;
            au_col = in_col;
        end
        else if (in_char == tcsw_pkg::CH_BS)
        begin
            au_row = bs_y;
            au_col = bs_x;
        end
        else
        begin
            au_row = cursor_y_reg;
            au_col = cursor_x_reg;
        end
    end
    assign au_addr = tcsw_pkg::cell_addr(au_row, au_col);

    // Scroll reads one row ahead of the cell it writes
    assign rd_addr = (state_reg == tcsw_pkg::ST_SCROLL) ?
                     (scan_reg + AW'(tcsw_pkg::COLS)) : au_addr;

    always_comb
    begin
        state_next     = state_reg;
        scan_next      = scan_reg;
        cursor_x_next  = cursor_x_reg;
        cursor_y_next  = cursor_y_reg;
        blink_next     = blink_reg;
        res_char_next  = res_char_reg;
        res_color_next = res_color_reg;
        res_oor_next   = res_oor_reg;
        wr_next        = '0;

        unique case (state_reg)
            tcsw_pkg::ST_CLEAR:
            begin
                // After reset, blank one cell a cycle
                wr_next.valid    = 1'b1;
                wr_next.addr     = scan_reg;
                wr_next.color_en = 1'b1;
                wr_next.chr      = tcsw_pkg::CH_SPACE;
                wr_next.color    = tcsw_pkg::RESET_CELL_COLOR;
                scan_next        = scan_reg + AW'(1);
                if (scan_reg == AW'(tcsw_pkg::CELLS - 1))
                begin
                    state_next = tcsw_pkg::ST_IDLE;
                end
            end

            tcsw_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    res_char_next  = 8'd0;
                    res_color_next = 32'd0;
                    res_oor_next   = 1'b0;
                    state_next     = tcsw_pkg::ST_RESP;
                    unique case (op)
                        tcsw_pkg::OP_WRITE:
                        begin
                            blink_next = 5'd0;
                            if (in_char == tcsw_pkg::CH_BS)
                            begin
                                // Space keeps the cell's colour
                                cursor_x_next = bs_x;
                                cursor_y_next = bs_y;
                                wr_next.valid = 1'b1;
                                wr_next.addr  = au_addr;
                                wr_next.chr   = tcsw_pkg::CH_SPACE;
                            end
                            else if (in_char == tcsw_pkg::CH_CR)
                            begin
                                cursor_x_next = 8'd0;
                            end
                            else
                            begin
                                if (in_char != tcsw_pkg::CH_LF)
                                begin
                                    wr_next.valid    = 1'b1;
                                    wr_next.addr     = au_addr;
                                    wr_next.color_en = 1'b1;
                                    wr_next.chr      = in_char;
                                    wr_next.color    = text_color_reg;
                                    cursor_x_next    = adv_x[7:0];
                                end
                                // New line on a line feed or a wrap at the last column
                                if (in_char == tcsw_pkg::CH_LF ||
                                    adv_x >= 9'(tcsw_pkg::COLS))
                                begin
                                    cursor_x_next = 8'd0;
                                    if (cursor_y_reg >= 8'(tcsw_pkg::ROWS - 1))
                                    begin
                                        scan_next  = '0;
                                        state_next = tcsw_pkg::ST_SCROLL;
                                    end
                                    else
                                    begin
                                        cursor_y_next = cursor_y_reg + 8'd1;
                                    end
                                end
                            end
                        end

                        tcsw_pkg::OP_READ:
                        begin
                            if (in_oor)
                            begin
                                res_oor_next = 1'b1;
                            end
                            else
                            begin
                                state_next = tcsw_pkg::ST_READ;
                            end
                        end

                        tcsw_pkg::OP_TICK:
                        begin
                            blink_next = (blink_reg == tcsw_pkg::BLINK_LAST) ?
                                         5'd0 : blink_reg + 5'd1;
                        end

                        tcsw_pkg::OP_NOP:
                        begin
                        end

                        default:
                        begin
                        end
                    endcase
                end
            end

            tcsw_pkg::ST_READ:
            begin
                res_char_next  = rd_char_reg;
                res_color_next = rd_color_reg;
                state_next     = tcsw_pkg::ST_RESP;
            end

            tcsw_pkg::ST_SCROLL:
            begin
                // Copy cell scan+COLS to scan once its read data is back
                wr_next.valid    = 1'b1;
                wr_next.addr     = scan_reg;
                wr_next.from_mem = 1'b1;
                wr_next.color_en = 1'b1;
                scan_next        = scan_reg + AW'(1);
                if (scan_reg == AW'(tcsw_pkg::CELLS - tcsw_pkg::COLS - 1))
                begin
                    state_next = tcsw_pkg::ST_FILL;
                end
            end

            tcsw_pkg::ST_FILL:
            begin
                wr_next.valid    = 1'b1;
                wr_next.addr     = scan_reg;
                wr_next.color_en = 1'b1;
                wr_next.chr      = tcsw_pkg::CH_SPACE;
                wr_next.color    = text_color_reg;
                scan_next        = scan_reg + AW'(1);
                if (scan_reg == AW'(tcsw_pkg::CELLS - 1))
                begin
                    state_next = tcsw_pkg::ST_RESP;
                end
            end

            tcsw_pkg::ST_RESP:
            begin
                if (out_free)
                begin
                    state_next = tcsw_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = tcsw_pkg::ST_IDLE;
            end
        endcase
    end

    // Cell memories: registered read, queued write
    always_ff @(posedge clk)
    begin
        rd_char_reg  <= char_mem[rd_addr];
        rd_color_reg <= color_mem[rd_addr];
        if (wr_reg.valid)
        begin
            char_mem[wr_reg.addr] <= wr_reg.from_mem ? rd_char_reg : wr_reg.chr;
            if (wr_reg.color_en)
            begin
                color_mem[wr_reg.addr] <= wr_reg.from_mem ? rd_color_reg : wr_reg.color;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        res_char_reg  <= res_char_next;
        res_color_reg <= res_color_next;
        res_oor_reg   <= res_oor_next;
        if (state_reg == tcsw_pkg::ST_RESP && out_free)
        begin
            m_tdata_reg <= {6'd0, res_oor_reg, cursor_visible, res_color_reg,
                            res_char_reg, cursor_y_reg, cursor_x_reg};
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= tcsw_pkg::ST_CLEAR;
            scan_reg          <= '0;
            wr_reg            <= '0;
            text_color_reg    <= tcsw_pkg::RESET_TEXT_COLOR;
            cursor_enable_reg <= 1'b1;
            cursor_x_reg      <= 8'd0;
            cursor_y_reg      <= 8'd0;
            blink_reg         <= 5'd0;
            m_tvalid_reg      <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            scan_reg     <= scan_next;
            wr_reg       <= wr_next;
            cursor_x_reg <= cursor_x_next;
            cursor_y_reg <= cursor_y_next;
            blink_reg    <= blink_next;

            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    tcsw_pkg::REG_TEXT_COLOR:    text_color_reg    <= cfg_data;
                    tcsw_pkg::REG_CURSOR_ENABLE: cursor_enable_reg <= cfg_data[0];
                    default:
                    begin
                    end
                endcase
            end

            // Load a finished result, or drop the old one once taken
            if (state_reg == tcsw_pkg::ST_RESP && out_free)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

endmodule

[dv/tb.sv]
// Self-checking testbench for the text console screen writer.
`timescale 1ns / 1ps

module tb;

    // Result word as it sits on m_tdata, lowest field last in the list.
    typedef struct packed {
        logic [5:0]  pad;
        logic        off_screen;
        logic        shown;
        logic [31:0] tint;
        logic [7:0]  glyph;
        logic [7:0]  row;
        logic [7:0]  col;
    } console_reply_t;

    // Keeps its own copy of the screen, cursor and blink phase and the replies
    // that the accepted items must produce, oldest first.
    class console_scoreboard;
        bit [7:0]       glyphs [tcsw_pkg::CELLS];
        bit [31:0]      tints  [tcsw_pkg::CELLS];
        int unsigned    col_pos;
        int unsigned    row_pos;
        int unsigned    blink;
        bit [31:0]      ink;
        bit             cursor_on;
        console_reply_t replies_due [$];
        int             mismatches;
        int             checked;
        int             writes;
        int             reads;
        int             off_screen_reads;
        int             ticks;
        int             scrolls;

        function new();
            for (int i = 0; i < tcsw_pkg::CELLS; i++)
            begin
                glyphs[i] = tcsw_pkg::CH_SPACE;
                tints[i]  = tcsw_pkg::RESET_CELL_COLOR;
            end
            ink       = tcsw_pkg::RESET_TEXT_COLOR;
            cursor_on = 1'b1;
        endfunction

        function void set_reg(input logic [7:0] index, input logic [31:0] data);
            if (index == tcsw_pkg::REG_TEXT_COLOR)
                ink = data;
            else if (index == tcsw_pkg::REG_CURSOR_ENABLE)
                cursor_on = data[0];
        endfunction

        // New line; on the bottom row shift every row up and blank the last one.
        function void feed_line();
            col_pos = 0;
            if (row_pos < tcsw_pkg::ROWS - 1)
                row_pos++;
            else
            begin
                for (int i = 0; i < tcsw_pkg::CELLS - tcsw_pkg::COLS; i++)
                begin
                    glyphs[i] = glyphs[i + tcsw_pkg::COLS];
                    tints[i]  = tints[i + tcsw_pkg::COLS];
                end
                for (int i = tcsw_pkg::CELLS - tcsw_pkg::COLS; i < tcsw_pkg::CELLS; i++)
                begin
                    glyphs[i] = tcsw_pkg::CH_SPACE;
                    tints[i]  = ink;
                end
                scrolls++;
            end
        endfunction

        function void put_byte(input logic [7:0] chr);
            int unsigned spot;
            case (chr)
                tcsw_pkg::CH_BS:
                begin
                    // Step back, wrapping to the end of the row above; home stays put.
                    if (col_pos != 0)
                        col_pos--;
                    else if (row_pos != 0)
                    begin
                        col_pos = tcsw_pkg::COLS - 1;
                        row_pos--;
                    end
                    glyphs[row_pos * tcsw_pkg::COLS + col_pos] = tcsw_pkg::CH_SPACE;
                end
                tcsw_pkg::CH_CR:
                    col_pos = 0;
                tcsw_pkg::CH_LF:
                    feed_line();
                default:
                begin
                    spot         = row_pos * tcsw_pkg::COLS + col_pos;
                    glyphs[spot] = chr;
                    tints[spot]  = ink;
                    col_pos++;
                    if (col_pos >= tcsw_pkg::COLS)
                        feed_line();
                end
            endcase
            blink = 0;
        endfunction

        function void note_item(input tcsw_pkg::op_t op, input logic [7:0] chr,
                                input logic [7:0] col, input logic [7:0] row);
            console_reply_t want;
            int unsigned    spot;
            want = '0;
            case (op)
                tcsw_pkg::OP_WRITE:
                begin
                    put_byte(chr);
                    writes++;
                end
                tcsw_pkg::OP_READ:
                begin
                    reads++;
                    if (col >= tcsw_pkg::COLS || row >= tcsw_pkg::ROWS)
                    begin
                        want.off_screen = 1'b1;
                        off_screen_reads++;
                    end
                    else
                    begin
                        spot       = row * tcsw_pkg::COLS + col;
                        want.glyph = glyphs[spot];
                        want.tint  = tints[spot];
                    end
                end
                tcsw_pkg::OP_TICK:
                begin
                    blink = (blink >= tcsw_pkg::BLINK_LAST) ? 0 : blink + 1;
                    ticks++;
                end
                default:
                    ;
            endcase
            want.col   = 8'(col_pos);
            want.row   = 8'(row_pos);
            want.shown = cursor_on && (blink < tcsw_pkg::BLINK_SHOWN);
            replies_due.insert(replies_due.size(), want);
        endfunction

        function void check_reply(input logic [63:0] word);
            console_reply_t got;
            console_reply_t want;
            got = console_reply_t'(word);
            if (replies_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected reply %h with nothing outstanding", word);
                return;
            end
            want = replies_due.pop_front();
            checked++;
            if (got.col !== want.col || got.row !== want.row || got.glyph !== want.glyph ||
                got.tint !== want.tint || got.shown !== want.shown ||
                got.off_screen !== want.off_screen || got.pad !== want.pad)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("reply %0d mismatch (expected/actual): col %0d/%0d row %0d/%0d chr %h/%h",
                             checked, want.col, got.col, want.row, got.row, want.glyph, got.glyph);
                    $display("    color %h/%h visible %b/%b off-screen %b/%b fill %h/%h",
                             want.tint, got.tint, want.shown, got.shown,
                             want.off_screen, got.off_screen, want.pad, got.pad);
                end
            end
        endfunction
    endclass

    localparam int STALL_LIMIT     = 25000;  // cycles with no transfer on any channel
    localparam int HOLD_CYCLES     = 300;    // long result back-pressure, once
    localparam int DRAIN_CYCLES    = 50;
    localparam int ITEMS_PER_STAGE = 65;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [7:0]  cfg_index;
    logic [31:0] cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;    // char_byte[7:0], cell_col[15:8], cell_row[23:16]
    logic [1:0]  s_tuser;    // opcode[1:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;    // cursor_col[7:0], cursor_row[15:8], cell_char[23:16],
                             // cell_color[55:24], cursor_visible[56], out_of_range[57]

    console_scoreboard sb = new();

    bit steady_flow   = 1'b0;   // both sides stop idling while set
    bit hold_request  = 1'b0;   // ask the receiver for its long hold-off
    int hold_count    = 0;
    int items_sent    = 0;
    int quiet_cycles  = 0;

    text_console_screen_writer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Receiver: random back-pressure, none during the steady stretch, and one
    // long hold-off counted here while the sender keeps pushing items.
    always @(posedge clk)
    begin
        if (hold_request && hold_count < HOLD_CYCLES)
        begin
            m_tready <= 1'b0;
            hold_count++;
        end
        else if (steady_flow)
            m_tready <= 1'b1;
        else
            m_tready <= ($urandom_range(0, 99) >= 30);
    end

    // Check every result transfer against the oldest outstanding prediction.
    always @(posedge clk)
    begin
        if (m_tvalid === 1'b1 && m_tready === 1'b1)
            sb.check_reply(m_tdata);
    end

    // Watchdog: give up when no channel has moved a transfer for too long.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("timeout after %0d cycles without a transfer", STALL_LIMIT);
            $display("tb failed");
            $finish;
        end
    end

    // Offer one item, with a random gap first, and hold it until it is taken.
    // Valid stays high on exit so that a following item goes out back to back.
    task automatic send_item(input tcsw_pkg::op_t op, input logic [7:0] chr,
                             input logic [7:0] col, input logic [7:0] row);
        int gap;
        gap = 0;
        if (!steady_flow)
            while ($urandom_range(0, 99) < 30)
                gap++;
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {row, col, chr};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_item(op, chr, col, row);
        items_sent++;
    endtask

    // Write one register; cfg_valid is left high for a following write.
    task automatic write_reg(input logic [7:0] index, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.set_reg(index, data);
    endtask

    // Drop valid and wait until every outstanding result has come back.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (sb.replies_due.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int          pick;
        int          count;
        int          tail;
        int          stage_start;
        logic [31:0] ink;
        logic        enable;
        logic [7:0]  rc;
        logic [7:0]  rr;

        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= tcsw_pkg::OP_NOP;
        cfg_valid <= 1'b0;
        cfg_index <= tcsw_pkg::REG_TEXT_COLOR;
        cfg_data  <= '0;
        m_tready  <= 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed items under the reset register values.
        // Blank cell after the sweep, far corner, just right of and just below the screen.
        send_item(tcsw_pkg::OP_READ, 8'h00, 8'd0, 8'd0);
        send_item(tcsw_pkg::OP_READ, 8'hFF, 8'(tcsw_pkg::COLS - 1), 8'(tcsw_pkg::ROWS - 1));
        send_item(tcsw_pkg::OP_READ, 8'h00, 8'(tcsw_pkg::COLS), 8'd0);
        send_item(tcsw_pkg::OP_READ, 8'h00, 8'd0, 8'(tcsw_pkg::ROWS));
        send_item(tcsw_pkg::OP_READ, 8'h00, 8'hFF, 8'hFF);
        send_item(tcsw_pkg::OP_WRITE, tcsw_pkg::CH_BS, 8'h00, 8'h00);  // home stays put
        send_item(tcsw_pkg::OP_WRITE, 8'hFF, 8'hFF, 8'hFF);
        send_item(tcsw_pkg::OP_WRITE, 8'h00, 8'h00, 8'h00);
        send_item(tcsw_pkg::OP_WRITE, 8'h41, 8'hA5, 8'h5A);
        send_item(tcsw_pkg::OP_TICK, 8'hFF, 8'hFF, 8'hFF);
        send_item(tcsw_pkg::OP_WRITE, tcsw_pkg::CH_BS, 8'h00, 8'h00);  // colour kept
        send_item(tcsw_pkg::OP_READ, 8'h00, 8'd2, 8'd0);
        send_item(tcsw_pkg::OP_READ, 8'h00, 8'd1, 8'd0);
        send_item(tcsw_pkg::OP_WRITE, tcsw_pkg::CH_CR, 8'h00, 8'h00);
        send_item(tcsw_pkg::OP_WRITE, tcsw_pkg::CH_LF, 8'h00, 8'h00);
        // Wraps back to the end of row 0
        send_item(tcsw_pkg::OP_WRITE, tcsw_pkg::CH_BS, 8'h00, 8'h00);
        send_item(tcsw_pkg::OP_READ, 8'h00, 8'(tcsw_pkg::COLS - 1), 8'd0);
        // Last column, wraps to a new line
        send_item(tcsw_pkg::OP_WRITE, 8'h7E, 8'h00, 8'h00);
        send_item(tcsw_pkg::OP_READ, 8'h00, 8'(tcsw_pkg::COLS - 1), 8'd0);
        send_item(tcsw_pkg::OP_NOP, 8'hFF, 8'hFF, 8'hFF);
        wait_drained();

        // Random stages, each under its own register setting.
        for (int stage = 0; stage < 4; stage++)
        begin
            case (stage)
                0:
                begin
                    ink    = 32'h0000_0000;
                    enable = 1'b0;
                end
                1:
                begin
                    ink         = 32'hFFFF_FFFF;
                    enable      = 1'b1;
                    steady_flow = 1'b1;
                end
                2:
                begin
                    ink          = $urandom;
                    enable       = 1'b1;
                    steady_flow  = 1'b0;
                    hold_request = 1'b1;
                end
                default:
                begin
                    ink    = $urandom;
                    enable = 1'($urandom_range(0, 1));
                end
            endcase
            write_reg(tcsw_pkg::REG_TEXT_COLOR, ink);
            write_reg(tcsw_pkg::REG_CURSOR_ENABLE, {31'b0, enable});
            cfg_valid <= 1'b0;

            stage_start = items_sent;
            while (items_sent - stage_start < ITEMS_PER_STAGE)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 38)
                begin
                    // A run of text, mostly printable, usually closed by a new line.
                    count = $urandom_range(1, 12);
                    repeat (count)
                        send_item(tcsw_pkg::OP_WRITE,
                                  ($urandom_range(0, 3) != 0) ? 8'($urandom_range(8'h21, 8'h7E))
                                                              : 8'($urandom),
                                  8'($urandom), 8'($urandom));
                    tail = $urandom_range(0, 9);
                    if (tail < 4)
                        send_item(tcsw_pkg::OP_WRITE, tcsw_pkg::CH_CR,
                                  8'($urandom), 8'($urandom));
                    if (tail < 8)
                        send_item(tcsw_pkg::OP_WRITE, tcsw_pkg::CH_LF,
                                  8'($urandom), 8'($urandom));
                end
                else if (pick < 50)
                begin
                    // A burst of line feeds pushes the cursor down and scrolls.
                    count = $urandom_range(1, 6);
                    repeat (count)
                        send_item(tcsw_pkg::OP_WRITE, tcsw_pkg::CH_LF,
                                  8'($urandom), 8'($urandom));
                end
                else if (pick < 58)
                begin
                    count = $urandom_range(1, 3);
                    repeat (count)
                        send_item(tcsw_pkg::OP_WRITE, tcsw_pkg::CH_BS,
                                  8'($urandom), 8'($urandom));
                end
                else if (pick < 64)
                    send_item(tcsw_pkg::OP_WRITE, tcsw_pkg::CH_CR, 8'($urandom), 8'($urandom));
                else if (pick < 84)
                begin
                    // Reads aim mostly at the cursor row and the cell just written.
                    tail = $urandom_range(0, 9);
                    rr   = 8'(sb.row_pos);
                    if (tail < 4)
                        rc = 8'($urandom_range(0, tcsw_pkg::COLS - 1));
                    else if (tail < 6)
                        rc = (sb.col_pos != 0) ? 8'(sb.col_pos - 1) : 8'd0;
                    else if (tail < 8)
                    begin
                        rc = 8'($urandom_range(0, tcsw_pkg::COLS - 1));
                        rr = 8'($urandom_range(0, tcsw_pkg::ROWS - 1));
                    end
                    else if (tail == 8)
                    begin
                        rc = 8'($urandom_range(tcsw_pkg::COLS, 255));
                        rr = 8'($urandom);
                    end
                    else
                    begin
                        rc = 8'($urandom);
                        rr = 8'($urandom_range(tcsw_pkg::ROWS, 255));
                    end
                    send_item(tcsw_pkg::OP_READ, 8'($urandom), rc, rr);
                end
                else if (pick < 95)
                begin
                    // Ticks; the long burst crosses the show limit and the wrap.
                    count = ($urandom_range(0, 3) == 0) ? 31 : $urandom_range(1, 10);
                    repeat (count)
                        send_item(tcsw_pkg::OP_TICK, 8'($urandom), 8'($urandom), 8'($urandom));
                end
                else
                    send_item(tcsw_pkg::OP_NOP, 8'($urandom), 8'($urandom), 8'($urandom));
            end
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d items: %0d writes, %0d reads (%0d off screen), %0d ticks",
                 items_sent, sb.writes, sb.reads, sb.off_screen_reads, sb.ticks);
        $display("%0d results checked, %0d scrolls, five register settings, one long stall",
                 sb.checked, sb.scrolls);
        if (sb.replies_due.size() != 0)
            $display("%0d results never arrived", sb.replies_due.size());
        if (sb.mismatches == 0 && sb.replies_due.size() == 0)
            $display("tb passed");
        else
        begin
            $display("%0d mismatches", sb.mismatches);
            $display("tb failed");
        end
        $finish;
    end

endmodule
